@@ rtl/frc_pkg.sv @@
// Shared constants and a helper function for the Faraday rotation correction unit.
package frc_pkg;

  localparam int FREQ_W = 24;
  localparam int DSQ_W = 2 * FREQ_W;
  localparam int RM_W = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int DIV_STEPS = 64;
  localparam int CORDIC_STEPS = 28;
  localparam int CW = 34;
  localparam int PHASE_W = 32;

  localparam logic [63:0] TURN_SCALE = 64'd8052510968107438407;
  localparam logic signed [CW-1:0] CORDIC_START = 34'sd652032874;
  localparam logic [FREQ_W-1:0] FC_RESET = 24'd358400;

  // register indexes (paddr word select)
  localparam logic [1:0] REG_RM = 2'd0;
  localparam logic [1:0] REG_RMI = 2'd1;
  localparam logic [1:0] REG_FC = 2'd2;

  // arctangent of 2^-i in 2^-32 turn
  function automatic logic [PHASE_W-1:0] atan_turn(input int i);
    logic [PHASE_W-1:0] v;
    case (i)
      0: v = 32'd536870912;
      1: v = 32'd316933406;
      2: v = 32'd167458907;
      3: v = 32'd85004756;
      4: v = 32'd42667331;
      5: v = 32'd21354465;
      6: v = 32'd10679838;
      7: v = 32'd5340245;
      8: v = 32'd2670163;
      9: v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      24: v = 32'd41;
      25: v = 32'd20;
      26: v = 32'd10;
      27: v = 32'd5;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/frc_if.sv @@
// Request channel interfaces for the sample input and the corrected output.
interface frc_in_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic [23:0]                    channel_frequency;
  logic signed [SAMPLE_WIDTH-1:0] q_in;
  logic signed [SAMPLE_WIDTH-1:0] u_in;

  modport source (output valid, channel_frequency, q_in, u_in, input ready);
  modport sink (input valid, channel_frequency, q_in, u_in, output ready);
endinterface

interface frc_out_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] q_out;
  logic signed [SAMPLE_WIDTH-1:0] u_out;

  modport source (output valid, q_out, u_out, input ready);
  modport sink (input valid, q_out, u_out, output ready);
endinterface

@@ rtl/frc_recip.sv @@
// Pipelined restoring divider: TURN_SCALE / divisor, one quotient bit per stage.
module frc_recip (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [frc_pkg::DSQ_W-1:0] dsq_i,
  output logic [63:0]               quot_o
);
  import frc_pkg::*;

  logic [DSQ_W-1:0] rem_q [DIV_STEPS];
  logic [DSQ_W-1:0] div_q [DIV_STEPS];
  logic [63:0]      quo_q [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
    logic [DSQ_W-1:0] rem_in;
    logic [DSQ_W-1:0] div_in;
    logic [63:0]      quo_in;
    logic [DSQ_W:0]   trial;
    logic [DSQ_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign div_in = dsq_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign div_in = div_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign trial = {rem_in, TURN_SCALE[63-k]};
    assign diff  = trial - {1'b0, div_in};
    assign ge    = (trial >= {1'b0, div_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[DSQ_W-1:0] : trial[DSQ_W-1:0];
        div_q[k] <= div_in;
        quo_q[k] <= {quo_in[62:0], ge};
      end
    end
  end

  assign quot_o = quo_q[DIV_STEPS-1];

endmodule

@@ rtl/frc_cordic.sv @@
// Pipelined rotation-mode CORDIC, one micro-rotation per stage, quadrant carried along.
module frc_cordic (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [frc_pkg::PHASE_W-1:0] z_i,
  input  logic [1:0]                         quad_i,
  output logic signed [frc_pkg::CW-1:0]      x_o,
  output logic signed [frc_pkg::CW-1:0]      y_o,
  output logic [1:0]                         quad_o
);
  import frc_pkg::*;

  logic signed [CW-1:0] x_q [CORDIC_STEPS];
  logic signed [CW-1:0] y_q [CORDIC_STEPS];
  logic signed [CW-1:0] z_q [CORDIC_STEPS];
  logic [1:0]           qd_q [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    logic signed [CW-1:0] x_in;
    logic signed [CW-1:0] y_in;
    logic signed [CW-1:0] z_in;
    logic [1:0]           qd_in;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] at;

    if (i == 0) begin : g_first
      assign x_in  = CORDIC_START;
      assign y_in  = '0;
      assign z_in  = CW'(z_i);
      assign qd_in = quad_i;
    end else begin : g_next
      assign x_in  = x_q[i-1];
      assign y_in  = y_q[i-1];
      assign z_in  = z_q[i-1];
      assign qd_in = qd_q[i-1];
    end

    // arithmetic shift floors negative values
    assign dx = y_in >>> i;
    assign dy = x_in >>> i;
    assign at = $signed({{(CW-PHASE_W){1'b0}}, atan_turn(i)});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_in[CW-1]) begin
          x_q[i] <= x_in - dx;
          y_q[i] <= y_in + dy;
          z_q[i] <= z_in - at;
        end else begin
          x_q[i] <= x_in + dx;
          y_q[i] <= y_in - dy;
          z_q[i] <= z_in + at;
        end
        qd_q[i] <= qd_in;
      end
    end
  end

  assign x_o    = x_q[CORDIC_STEPS-1];
  assign y_o    = y_q[CORDIC_STEPS-1];
  assign quad_o = qd_q[CORDIC_STEPS-1];

endmodule

@@ rtl/frc_mix.sv @@
// Quadrant fold, Q/U rotation products, rounding and saturation to the sample range.
module frc_mix #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [frc_pkg::CW-1:0]    x_i,
  input  logic signed [frc_pkg::CW-1:0]    y_i,
  input  logic [1:0]                       quad_i,
  input  logic signed [SAMPLE_WIDTH-1:0]   q_i,
  input  logic signed [SAMPLE_WIDTH-1:0]   u_i,
  output logic signed [SAMPLE_WIDTH-1:0]   q_o,
  output logic signed [SAMPLE_WIDTH-1:0]   u_o
);
  import frc_pkg::*;

  localparam int PW = SAMPLE_WIDTH + CW;
  localparam int SW2 = PW + 2;
  localparam int RW = SW2 - 30;

  logic signed [CW-1:0]  cs;
  logic signed [CW-1:0]  sn;
  logic signed [PW-1:0]  qc_q;
  logic signed [PW-1:0]  us_q;
  logic signed [PW-1:0]  uc_q;
  logic signed [PW-1:0]  qs_q;
  logic signed [SW2-1:0] sum_q;
  logic signed [SW2-1:0] sum_u;
  logic signed [RW-1:0]  rq;
  logic signed [RW-1:0]  ru;

  always_comb begin
    case (quad_i)
      2'd0: begin
        cs = x_i;
        sn = y_i;
      end
      2'd1: begin
        cs = -y_i;
        sn = x_i;
      end
      2'd2: begin
        cs = -x_i;
        sn = -y_i;
      end
      default: begin
        cs = y_i;
        sn = -x_i;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qc_q <= PW'(q_i * cs);
      us_q <= PW'(u_i * sn);
      uc_q <= PW'(u_i * cs);
      qs_q <= PW'(q_i * sn);
    end
  end

  // round half up at bit 29, then drop 30 fraction bits
  assign sum_q = SW2'(qc_q) - SW2'(us_q) + SW2'(34'sd536870912);
  assign sum_u = SW2'(uc_q) + SW2'(qs_q) + SW2'(34'sd536870912);
  assign rq = sum_q[SW2-1:30];
  assign ru = sum_u[SW2-1:30];

  function automatic logic signed [SAMPLE_WIDTH-1:0] sat(input logic signed [RW-1:0] v);
    logic fits;
    fits = (v[RW-1:SAMPLE_WIDTH-1] == '0) || (v[RW-1:SAMPLE_WIDTH-1] == '1);
    if (fits) return v[SAMPLE_WIDTH-1:0];
    else if (v[RW-1]) return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    else return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  endfunction

  assign q_o = sat(rq);
  assign u_o = sat(ru);

endmodule

@@ rtl/faraday_rotation_correct_unit.sv @@
// Top level: APB registers, stage pipeline control and datapath of the rotation corrector.
// Throughput: one request per cycle while the output is not stalled; the 64-stage reciprocal divider sets the depth.
// The pipeline advances as one; it also moves while a result waits if its last stage is empty.
// Reset clears all valid bits and loads the registers (rotation measures 0, centre 358400).
// No clearing pass after reset: requests are taken on the first cycle out of reset.
module faraday_rotation_correct_unit #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  frc_in_if.sink                             in_ch,
  frc_out_if.source                          out_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [frc_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [frc_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [frc_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import frc_pkg::*;

  // stage map: 0 squares, 1..64 divider, 65 multiply, 66 phase sum,
  // 67..94 CORDIC, 95 products; then the output register
  localparam int ST_DIV = DIV_STEPS;
  localparam int ST_M1 = ST_DIV + 1;
  localparam int ST_M2 = ST_M1 + 1;
  localparam int ST_CO = ST_M2 + CORDIC_STEPS;
  localparam int NST = ST_CO + 2;
  localparam int QU_N = ST_CO + 1;

  // configuration registers
  logic signed [RM_W-1:0] rm_q;
  logic signed [RM_W-1:0] rmi_q;
  logic [FREQ_W-1:0]      fc_q;
  logic                   cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rm_q  <= '0;
      rmi_q <= '0;
      fc_q  <= FC_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_RM:  rm_q  <= pwdata;
        REG_RMI: rmi_q <= pwdata;
        REG_FC:  fc_q  <= pwdata[FREQ_W-1:0];
        default: ;  // drop writes to unmapped addresses
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_RM:  prdata = rm_q;
      REG_RMI: prdata = rmi_q;
      REG_FC:  prdata = {{(CFG_DATA_W-FREQ_W){1'b0}}, fc_q};
      default: prdata = '0;
    endcase
  end

  // pipeline control: advance when the last stage is empty or the output can load
  logic [NST-1:0] v_q;
  logic           out_valid_q;
  logic           out_load;
  logic           en;
  logic           accept;

  assign out_load = !out_valid_q || out_ch.ready;
  assign en       = !v_q[NST-1] || out_load;
  assign in_ch.ready = en;
  assign accept   = in_ch.valid && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NST-2:0], accept};
    end
  end

  // stage 0: squared frequencies, zero treated as one
  logic [FREQ_W-1:0] f_eff;
  logic [FREQ_W-1:0] fc_eff;
  logic [DSQ_W-1:0]  dsq_f_q;
  logic [DSQ_W-1:0]  dsq_c_q;

  assign f_eff  = (in_ch.channel_frequency == '0) ? FREQ_W'(1) : in_ch.channel_frequency;
  assign fc_eff = (fc_q == '0) ? FREQ_W'(1) : fc_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dsq_f_q <= f_eff * f_eff;
      dsq_c_q <= fc_eff * fc_eff;
    end
  end

  // sample delay line, aligned with the CORDIC output
  logic signed [SAMPLE_WIDTH-1:0] q_pipe_q [QU_N];
  logic signed [SAMPLE_WIDTH-1:0] u_pipe_q [QU_N];

  always_ff @(posedge clk_i) begin
    if (en) begin
      q_pipe_q[0] <= in_ch.q_in;
      u_pipe_q[0] <= in_ch.u_in;
      for (int k = 1; k < QU_N; k++) begin
        q_pipe_q[k] <= q_pipe_q[k-1];
        u_pipe_q[k] <= u_pipe_q[k-1];
      end
    end
  end

  // per-unit-RM phase weights, 2^-48 turn
  logic [63:0] wf;
  logic [63:0] wc;

  frc_recip u_recip_f (
    .clk_i  (clk_i),
    .en_i   (en),
    .dsq_i  (dsq_f_q),
    .quot_o (wf)
  );

  frc_recip u_recip_c (
    .clk_i  (clk_i),
    .en_i   (en),
    .dsq_i  (dsq_c_q),
    .quot_o (wc)
  );

  // 64-bit products modulo 2^64 from 32x33 partial products
  logic [63:0] dw;
  logic [63:0] pa0_q;
  logic [31:0] pa1_q;
  logic [63:0] pb0_q;
  logic [31:0] pb1_q;

  assign dw = wc - wf;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa0_q <= 64'(rm_q * $signed({1'b0, dw[31:0]}));
      pa1_q <= 32'(rm_q * $signed({1'b0, dw[63:32]}));
      pb0_q <= 64'(rmi_q * $signed({1'b0, wf[31:0]}));
      pb1_q <= 32'(rmi_q * $signed({1'b0, wf[63:32]}));
    end
  end

  // phase in 2^-32 turn, split into quadrant and residual
  logic [63:0]        acc;
  logic [PHASE_W-1:0] ph;
  logic [PHASE_W-1:0] ph_rnd;
  logic [1:0]         quad;
  logic [PHASE_W-1:0] resid;
  logic signed [PHASE_W-1:0] z_q;
  logic [1:0]         quad_q;

  assign acc    = pa0_q + {pa1_q, 32'd0} - pb0_q - {pb1_q, 32'd0};
  assign ph     = acc[47:16];
  assign ph_rnd = ph + 32'h2000_0000;
  assign quad   = ph_rnd[31:30];
  assign resid  = ph - {quad, 30'd0};

  always_ff @(posedge clk_i) begin
    if (en) begin
      z_q    <= resid;
      quad_q <= quad;
    end
  end

  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;
  logic [1:0]           cquad;

  frc_cordic u_cordic (
    .clk_i  (clk_i),
    .en_i   (en),
    .z_i    (z_q),
    .quad_i (quad_q),
    .x_o    (cx),
    .y_o    (cy),
    .quad_o (cquad)
  );

  logic signed [SAMPLE_WIDTH-1:0] q_rot;
  logic signed [SAMPLE_WIDTH-1:0] u_rot;

  frc_mix #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_mix (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (cx),
    .y_i    (cy),
    .quad_i (cquad),
    .q_i    (q_pipe_q[QU_N-1]),
    .u_i    (u_pipe_q[QU_N-1]),
    .q_o    (q_rot),
    .u_o    (u_rot)
  );

  // output register: hold while the sink stalls
  logic signed [SAMPLE_WIDTH-1:0] q_out_q;
  logic signed [SAMPLE_WIDTH-1:0] u_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= v_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      q_out_q <= q_rot;
      u_out_q <= u_rot;
    end
  end

  assign out_ch.valid = out_valid_q;
  assign out_ch.q_out = q_out_q;
  assign out_ch.u_out = u_out_q;

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the Faraday rotation correction unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW = 32;
  localparam logic [63:0] PHASE_PER_RM = 64'd8052510968107438407;
  localparam longint GAIN_START = 64'sd652032874;
  localparam int ROT_STEPS = 28;
  localparam int DRAIN_CYCLES = 120;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

  // arctangent of 2^-i, in 2^-32 turn
  localparam longint ATAN_TURN [ROT_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5};

  typedef struct {
    logic signed [SW-1:0] q_out;
    logic signed [SW-1:0] u_out;
  } stokes_t;

  // Predicts each corrected Q,U pair and checks results in order.
  class rotation_scoreboard;
    logic signed [31:0] rm;
    logic signed [31:0] rmi;
    logic [23:0]        fc;
    stokes_t            pending_rotations[$];
    int                 err_cnt;

    function new();
      rm = 0;
      rmi = 0;
      fc = 24'd358400;
      err_cnt = 0;
    endfunction

    // phase per unit of rotation measure, in 2^-48 turn
    function logic [63:0] inv_square(logic [23:0] f);
      logic [63:0] ff;
      ff = (f == 0) ? 64'd1 : 64'(f) * 64'(f);
      return PHASE_PER_RM / ff;
    endfunction

    // a*ca + b*cb, rounded half up at 2^-30, saturated to the sample range
    function logic signed [SW-1:0] mix(logic signed [SW-1:0] a, longint ca,
                                       logic signed [SW-1:0] b, longint cb);
      logic signed [127:0] aw, bw, caw, cbw, s;
      aw = a;
      bw = b;
      caw = ca;
      cbw = cb;
      s = aw * caw + bw * cbw + (128'sd1 <<< 29);
      s = s >>> 30;
      if (s > 128'(S_MAX)) return S_MAX;
      if (s < 128'(S_MIN)) return S_MIN;
      return s[SW-1:0];
    endfunction

    function void note(logic [23:0] f, logic signed [SW-1:0] q,
                       logic signed [SW-1:0] u);
      logic [63:0] wc, wf, acc;
      logic [31:0] ph, rnd, res;
      logic [1:0]  quad;
      longint      x, y, z, dx, dy, cs, sn;
      stokes_t     r;
      wc = inv_square(fc);
      wf = inv_square(f);
      acc = 64'(longint'(rm)) * (wc - wf) - 64'(longint'(rmi)) * wf;
      ph = acc[47:16];
      rnd = ph + 32'h2000_0000;
      quad = rnd[31:30];
      res = ph - {quad, 30'b0};
      z = longint'($signed(res));
      x = GAIN_START;
      y = 0;
      for (int i = 0; i < ROT_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= ATAN_TURN[i];
        end else begin
          x += dx; y -= dy; z += ATAN_TURN[i];
        end
      end
      case (quad)
        2'd0: begin cs = x;  sn = y;  end
        2'd1: begin cs = -y; sn = x;  end
        2'd2: begin cs = -x; sn = -y; end
        default: begin cs = y; sn = -x; end
      endcase
      r.q_out = mix(q, cs, u, -sn);
      r.u_out = mix(u, cs, q, sn);
      pending_rotations.push_back(r);
    endfunction

    function void check(logic signed [SW-1:0] q, logic signed [SW-1:0] u);
      stokes_t e;
      if (pending_rotations.size() == 0) begin
        $error("unexpected result q_out=%0d u_out=%0d", q, u);
        err_cnt++;
        return;
      end
      e = pending_rotations.pop_front();
      if (q !== e.q_out) begin
        $error("q_out expected %0d actual %0d", e.q_out, q);
        err_cnt++;
      end
      if (u !== e.u_out) begin
        $error("u_out expected %0d actual %0d", e.u_out, u);
        err_cnt++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [frc_pkg::CFG_ADDR_W-1:0] paddr;
  logic [frc_pkg::CFG_DATA_W-1:0] pwdata;
  logic [frc_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  frc_in_if  #(.SAMPLE_WIDTH(SW)) in_ch ();
  frc_out_if #(.SAMPLE_WIDTH(SW)) out_ch ();

  faraday_rotation_correct_unit #(.SAMPLE_WIDTH(SW)) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rotation_scoreboard sb = new();

  int  idle_pct;     // chance in a hundred that the sender skips a cycle
  int  stall_pct;    // chance in a hundred that the receiver drops ready
  bit  hold_req;     // ask the receiver for one long hold-off

  // 8 ns clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver: check every accepted result, then pick ready for the next cycle.
  // A hold request keeps ready low for a long stretch so the pipe backs up.
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) sb.check(out_ch.q_out, out_ch.u_out);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_ni)
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Write one register through the setup and access cycles.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      frc_pkg::REG_RM:  sb.rm = value;
      frc_pkg::REG_RMI: sb.rmi = value;
      frc_pkg::REG_FC:  sb.fc = value[23:0];
      default: ;
    endcase
  endtask

  // Hold until every expected result has come back.
  task automatic drain();
    while (sb.pending_rotations.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_config(logic [31:0] rm, logic [31:0] rmi, logic [23:0] fc);
    drain();
    write_reg(frc_pkg::REG_RM, rm);
    write_reg(frc_pkg::REG_RMI, rmi);
    write_reg(frc_pkg::REG_FC, {8'b0, fc});
  endtask

  // Offer one request, idling first at the sender's rate, and hold it until taken.
  task automatic send_request(logic [23:0] f, logic [31:0] q, logic [31:0] u);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid             <= 1'b1;
    in_ch.channel_frequency <= f;
    in_ch.q_in              <= q;
    in_ch.u_in              <= u;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note(f, q, u);
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(7))
      0: return S_MAX;
      1: return S_MIN;
      2: return $urandom_range(2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [23:0] pick_freq();
    case ($urandom_range(9))
      0: return 24'd0;
      1: return 24'hFF_FFFF;
      2: return sb.fc;
      3: return 24'($urandom_range(4096, 1));
      4: return 24'(sb.fc + $urandom_range(512) - 256);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_batch(int count);
    repeat (count) send_request(pick_freq(), pick_sample(), pick_sample());
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [31:0] dir_q [8];
    logic [31:0] dir_u [8];
    logic [23:0] dir_f [4];

    rst_ni                  <= 1'b0;
    psel                    <= 1'b0;
    penable                 <= 1'b0;
    pwrite                  <= 1'b0;
    paddr                   <= '0;
    pwdata                  <= '0;
    in_ch.valid             <= 1'b0;
    in_ch.channel_frequency <= '0;
    in_ch.q_in              <= '0;
    in_ch.u_in              <= '0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset settings first (no rotation), then two rotating settings.
    // Cover zero, one and full-scale frequencies, and sample extremes that saturate.
    dir_q = '{S_MAX, S_MIN, S_MAX, S_MIN, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd12345};
    dir_u = '{S_MAX, S_MIN, S_MIN, S_MAX, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'hFFFE_0000};
    dir_f = '{24'd0, 24'd1, 24'hFF_FFFF, 24'd358400};
    for (int i = 0; i < 4; i++) send_request(dir_f[i], dir_q[i], dir_u[i]);
    in_ch.valid <= 1'b0;
    set_config(32'h0012_3400, 32'hFFFF_E1A0, 24'd358400);
    for (int i = 0; i < 8; i++) send_request(dir_f[i % 4], dir_q[i], dir_u[i]);
    // phase wrap: a huge rotation measure at a low frequency spans many turns
    send_request(24'd256, S_MAX, S_MIN);
    send_request(24'd2560, 32'd1000, 32'd2000);
    in_ch.valid <= 1'b0;
    set_config(32'h7FFF_FFFF, 32'h8000_0000, 24'd0);
    for (int i = 0; i < 8; i++) send_request(dir_f[i % 4], dir_q[i], dir_u[i]);
    in_ch.valid <= 1'b0;

    // Random phases, each with its own settings and idling mode.
    set_config(32'h8000_0000, 32'h7FFF_FFFF, 24'hFF_FFFF);
    idle_pct = 0;  stall_pct = 0;
    send_batch(55);
    set_config($urandom, $urandom, 24'($urandom));
    idle_pct = 83; stall_pct = 0;
    send_batch(55);
    set_config($urandom_range(1 << 20), 32'd0, 24'd1);
    idle_pct = 0;  stall_pct = 83;
    send_batch(55);
    set_config($urandom, $urandom, 24'd358400);
    idle_pct = 13; stall_pct = 13;
    send_batch(55);

    // Pressure: receiver holds off while the sender keeps the input full.
    set_config($urandom, $urandom, 24'($urandom));
    idle_pct = 0;  stall_pct = 0;
    hold_req = 1'b1;
    send_batch(160);

    set_config(32'd0, $urandom, 24'($urandom_range(24'hFF_FFFF, 1)));
    idle_pct = 13; stall_pct = 13;
    send_batch(40);
    set_config($urandom, 32'd0, 24'($urandom_range(1_000_000, 100_000)));
    idle_pct = 0;  stall_pct = 0;
    send_batch(40);

    // Let everything drain, then allow the pipe to settle.
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.err_cnt == 0 && sb.pending_rotations.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
